FILE: sv/pba_pkg.sv
// Shared definitions for the paged bump allocator: status codes, reset values
// and the command/status structures between controller and datapath.
// No dependencies.
package pba_pkg;

    localparam int MAX_PAGES_DEF  = 16;
    localparam int PAGE_BYTES_DEF = 4096;

    localparam int PSIZE_W = 13;
    localparam int USERS_W = 16;
    localparam int DATA_W  = 16;
    localparam int STAT_W  = 3;

    localparam logic [PSIZE_W-1:0] PAGE_SIZE_RST = 13'd4096;
    localparam logic [USERS_W-1:0] USERS_MAX     = 16'hFFFF;

    localparam logic [STAT_W-1:0] ST_ALLOC     = 3'd0;
    localparam logic [STAT_W-1:0] ST_OVERSIZE  = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOPAGES   = 3'd2;
    localparam logic [STAT_W-1:0] ST_FREED     = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTPOOLED = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic               load;
        logic               step;
        logic               upd;
        logic               open;
        logic               emit;
        logic [STAT_W-1:0]  status;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic oversize;
        logic hit;
        logic idx_zero;
        logic full;
        logic is_free;
    } t_dp_stat;

endpackage

FILE: sv/pba_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module pba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/pba_datapath.sv
// Datapath of the paged bump allocator: page size register, page count,
// search index, page table RAM, fit and range checks and the result register.
// Depends on pba_pkg and pba_ram.
module pba_datapath #(
    parameter int MAX_PAGES  = pba_pkg::MAX_PAGES_DEF,
    parameter int PAGE_BYTES = pba_pkg::PAGE_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pba_pkg::PSIZE_W-1:0]   i_cfg_wdata,
    input  logic                          i_func,
    input  logic [pba_pkg::DATA_W-1:0]    i_size,
    input  logic [pba_pkg::DATA_W-1:0]    i_address,
    input  pba_pkg::t_dp_cmd              i_cmd,
    output pba_pkg::t_dp_stat             o_stat,
    output logic                          o_valid,
    output logic [pba_pkg::STAT_W-1:0]    o_status,
    output logic [pba_pkg::DATA_W-1:0]    o_result_address
);

    import pba_pkg::*;

    localparam int IDX_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W  = $clog2(MAX_PAGES + 1);
    localparam int SPAN   = MAX_PAGES * PAGE_BYTES + (1 << PSIZE_W);
    localparam int BASE_W = ($clog2(SPAN) > DATA_W + 1) ? $clog2(SPAN) : DATA_W + 1;
    localparam int SUM_W  = DATA_W + 1;
    localparam int ENT_W  = PSIZE_W + USERS_W + PSIZE_W;

    logic [PSIZE_W-1:0] r_page_size;
    logic [CNT_W-1:0]   r_pages;
    logic               r_p0_wr;
    logic [IDX_W-1:0]   r_idx;
    logic               r_func;
    logic [DATA_W-1:0]  r_size;
    logic [DATA_W-1:0]  r_addr;
    logic               r_out_valid;
    logic [STAT_W-1:0]  r_status;
    logic [DATA_W-1:0]  r_res_addr;

    logic [ENT_W-1:0]   rd_data;
    logic [ENT_W-1:0]   wr_data;
    logic [IDX_W-1:0]   wr_addr;
    logic               wr_en;

    logic               use_rst;
    logic [PSIZE_W-1:0] fill;
    logic [USERS_W-1:0] users;
    logic [PSIZE_W-1:0] limit;
    logic [USERS_W-1:0] users_inc;
    logic [USERS_W-1:0] users_dec;
    logic [SUM_W-1:0]   fit_sum;
    logic               fit;
    logic [BASE_W-1:0]  base_cur;
    logic [BASE_W-1:0]  base_open;
    logic [BASE_W-1:0]  addr_x;
    logic               free_hit;
    logic [BASE_W-1:0]  hit_addr;
    logic [IDX_W-1:0]   open_idx;

    pba_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_PAGES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    // Page 0 is open from reset; until it is first written its entry reads
    // as empty with the full reset page size as its limit.
    assign use_rst = !r_p0_wr && (r_idx == '0);
    assign fill    = use_rst ? '0 : rd_data[ENT_W-1 -: PSIZE_W];
    assign users   = use_rst ? '0 : rd_data[PSIZE_W +: USERS_W];
    assign limit   = use_rst ? PAGE_SIZE_RST : rd_data[PSIZE_W-1:0];

    assign users_inc = (users == USERS_MAX) ? users : users + USERS_W'(1);
    assign users_dec = (users == '0) ? users : users - USERS_W'(1);

    assign fit_sum = SUM_W'(fill) + SUM_W'(r_size);
    assign fit     = SUM_W'(r_page_size) > fit_sum;

    assign base_cur  = BASE_W'(r_idx) * BASE_W'(PAGE_BYTES);
    assign base_open = BASE_W'(r_pages) * BASE_W'(PAGE_BYTES);
    assign addr_x    = BASE_W'(r_addr);
    assign free_hit  = (addr_x >= base_cur) && (addr_x < base_cur + BASE_W'(limit));
    assign hit_addr  = base_cur + BASE_W'(fill);
    assign open_idx  = r_pages[IDX_W-1:0];

    assign wr_en   = i_cmd.upd || i_cmd.open;
    assign wr_addr = i_cmd.open ? open_idx : r_idx;

    always_comb begin
        if (i_cmd.open) begin
            wr_data = {r_size[PSIZE_W-1:0], USERS_W'(1), r_page_size};
        end else if (r_func) begin
            wr_data = {(users_dec == '0) ? PSIZE_W'(0) : fill, users_dec, limit};
        end else begin
            wr_data = {fit_sum[PSIZE_W-1:0], users_inc, limit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size <= PAGE_SIZE_RST;
            r_pages     <= CNT_W'(1);
            r_p0_wr     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_page_size <= i_cfg_wdata;
            end
            if (i_cmd.open) begin
                r_pages <= r_pages + CNT_W'(1);
            end
            if (i_cmd.upd && (r_idx == '0)) begin
                r_p0_wr <= 1'b1;
            end
            r_out_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_size <= i_size;
            r_addr <= i_address;
            r_idx  <= IDX_W'(r_pages - CNT_W'(1));
        end else if (i_cmd.step) begin
            r_idx <= r_idx - IDX_W'(1);
        end
        if (i_cmd.emit) begin
            r_status <= i_cmd.status;
            if (i_cmd.open) begin
                r_res_addr <= base_open[DATA_W-1:0];
            end else if (i_cmd.upd && !r_func) begin
                r_res_addr <= hit_addr[DATA_W-1:0];
            end else begin
                r_res_addr <= '0;
            end
        end
    end

    assign o_stat.oversize = !r_func && (r_size > DATA_W'(r_page_size));
    assign o_stat.hit      = r_func ? free_hit : fit;
    assign o_stat.idx_zero = (r_idx == '0);
    assign o_stat.full     = (r_pages == CNT_W'(MAX_PAGES));
    assign o_stat.is_free  = r_func;

    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_result_address = r_res_addr;

endmodule

FILE: sv/pba_ctrl.sv
// Controller of the paged bump allocator: walks the page table from the newest
// page down, one page per table read, and issues update, open and emit commands.
// Depends on pba_pkg.
module pba_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  pba_pkg::t_dp_stat  i_stat,
    output pba_pkg::t_dp_cmd   o_cmd
);

    import pba_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_CHECK  = 2'd2;
    localparam logic [1:0] S_FETCH  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            // The first table read is in flight during this cycle.
            S_DECIDE: begin
                if (i_stat.oversize) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_OVERSIZE;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.hit) begin
                    o_cmd.upd    = 1'b1;
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = i_stat.is_free ? ST_FREED : ST_ALLOC;
                    n_state      = S_IDLE;
                end else if (i_stat.idx_zero) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                    if (i_stat.is_free) begin
                        o_cmd.status = ST_NOTPOOLED;
                    end else if (i_stat.full) begin
                        o_cmd.status = ST_NOPAGES;
                    end else begin
                        o_cmd.open   = 1'b1;
                        o_cmd.status = ST_ALLOC;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_CHECK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    // A transaction ends with exactly one emit, after which the block is idle.
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == S_IDLE))
        else $error("controller not idle after emitting a result");

    // A fresh page is never opened when the pool is exhausted or for a free request.
    a_open_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.open |-> (!i_stat.full && !i_stat.is_free))
        else $error("page opened with no room or on a free");

    // The table is only written when the result is delivered.
    a_write_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.upd || o_cmd.open) |-> o_cmd.emit)
        else $error("page table written without a result");

    // A new search is only started from idle.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> ($past(r_state) == S_IDLE || $past(o_cmd.emit) || $past(!i_rst_n)))
        else $error("search loaded while a transaction was in progress");

endmodule

FILE: sv/paged_bump_allocator.sv
// Paged bump allocator: one result per transaction, shown for one cycle on o_valid; the
// receiver cannot stall it. An oversize request is settled before any page is searched;
// otherwise pages are searched newest first, one table read each, until one settles it, and
// a full miss searches all pages in use (at most MAX_PAGES). Busy falls as the result is
// registered, so a new transaction can be accepted while the result is shown on o_valid.
// Synchronous reset leaves page 0 open and empty and page_size at 4096.
module paged_bump_allocator #(
    parameter int MAX_PAGES  = pba_pkg::MAX_PAGES_DEF,
    parameter int PAGE_BYTES = pba_pkg::PAGE_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pba_pkg::PSIZE_W-1:0]   i_cfg_wdata,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_func,
    input  logic [pba_pkg::DATA_W-1:0]    i_size,
    input  logic [pba_pkg::DATA_W-1:0]    i_address,
    output logic                          o_valid,
    output logic [pba_pkg::STAT_W-1:0]    o_status,
    output logic [pba_pkg::DATA_W-1:0]    o_result_address
);

    import pba_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    pba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    pba_datapath #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_func           (i_func),
        .i_size           (i_size),
        .i_address        (i_address),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_result_address (o_result_address)
    );

endmodule
